// ===== rtl/dcn_pkg.sv =====
// Shared types, constants and codes of the detection decoder with per-class NMS.
// Used by every module of the block; depends on nothing.
package dcn_pkg;

    localparam int MaxCandidatesDef = 1024;
    localparam int MaxKeptDef       = 64;
    localparam int MaxClassesDef    = 80;

    localparam logic [12:0] NetWidthRst   = 13'd640;
    localparam logic [12:0] NetHeightRst  = 13'd640;
    localparam logic [6:0]  NumClassesRst = 7'd80;
    localparam logic [16:0] ScoreThrRst   = 17'd32768;
    localparam logic [16:0] IouThrRst     = 17'd42598;

    typedef enum logic [2:0] {
        REG_NET_WIDTH  = 3'd0,
        REG_NET_HEIGHT = 3'd1,
        REG_NUM_CLASS  = 3'd2,
        REG_SCORE_THR  = 3'd3,
        REG_IOU_THR    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [12:0] net_width;
        logic [12:0] net_height;
        logic [6:0]  num_classes;
        logic [16:0] score_thr;
        logic [16:0] iou_thr;
    } t_cfg;

    typedef struct packed {
        logic [6:0]  cls;
        logic [16:0] score;
        logic [28:0] height;
        logic [28:0] width;
        logic [28:0] top;
        logic [28:0] left;
    } t_cand;

    typedef struct packed {
        logic  last;
        logic  ovf;
        logic  none;
        t_cand cand;
    } t_result;

    typedef struct packed {
        logic [28:0] lo;
        logic [28:0] len;
    } t_span;

    typedef enum logic [3:0] {
        S_LOAD,
        S_DRAIN,
        S_CLASS,
        S_PICK,
        S_SCAN,
        S_MARK,
        S_CMP_RD,
        S_CMP_GO,
        S_CMP_BUSY,
        S_KEEP,
        S_EMIT,
        S_E_RD,
        S_E_LD,
        S_OUT
    } t_nms_state;

endpackage

// ===== rtl/detection_decode_class_nms_top.sv =====
// Top level of the detection decoder with per-class greedy suppression.
// Depends on dcn_pkg, dcn_row_decode, dcn_nms and dcn_iou.
//
// Tensor values are taken one beat per cycle while a frame loads; each row is
// scored and decoded in a two-stage pipeline and kept as a candidate if it
// passes the score and size checks. The frame's last beat starts suppression
// and input is held off until the last result of the frame is taken.
// Suppression walks the candidate memory once per class and once more per
// picked box, one entry per cycle; each test against a kept box of the same
// class passes through the overlap unit, and each kept box is then read and
// held on the output until taken. The stores need no clearing pass after reset.
module detection_decode_class_nms_top import dcn_pkg::*; #(
    parameter int MAX_CANDIDATES = MaxCandidatesDef,
    parameter int MAX_KEPT       = MaxKeptDef,
    parameter int MAX_CLASSES    = MaxClassesDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [16:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // value
    input  logic         s_axis_tuser,  // last_of_row
    input  logic         s_axis_tlast,  // last_of_frame
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // box_left, box_top, box_width, box_height, confidence, class_index, zero pad
    output logic [143:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,  // none_found, overflowed
    output logic         m_axis_tlast   // last_result
);

    t_cfg    r_cfg;
    logic    beat;
    logic    cand_valid;
    t_cand   cand;
    t_result out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.net_width   <= NetWidthRst;
            r_cfg.net_height  <= NetHeightRst;
            r_cfg.num_classes <= NumClassesRst;
            r_cfg.score_thr   <= ScoreThrRst;
            r_cfg.iou_thr     <= IouThrRst;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NET_WIDTH:  r_cfg.net_width   <= i_cfg_data[12:0];
                REG_NET_HEIGHT: r_cfg.net_height  <= i_cfg_data[12:0];
                REG_NUM_CLASS:  r_cfg.num_classes <= i_cfg_data[6:0];
                REG_SCORE_THR:  r_cfg.score_thr   <= i_cfg_data;
                REG_IOU_THR:    r_cfg.iou_thr     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign beat = s_axis_tvalid && s_axis_tready;

    dcn_row_decode #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_row (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat       (beat),
        .i_value      (s_axis_tdata),
        .i_eor        (s_axis_tuser),
        .i_eof        (s_axis_tlast),
        .i_cfg        (r_cfg),
        .o_cand_valid (cand_valid),
        .o_cand       (cand)
    );

    dcn_nms #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .MAX_KEPT       (MAX_KEPT),
        .MAX_CLASSES    (MAX_CLASSES)
    ) u_nms (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cand_valid (cand_valid),
        .i_cand       (cand),
        .i_eof_beat   (beat && s_axis_tlast),
        .i_iou_thr    (r_cfg.iou_thr),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out        (out),
        .i_out_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {4'b0, out.cand};
    assign m_axis_tuser = {out.ovf, out.none};
    assign m_axis_tlast = out.last;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while results pending");

    a_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("input not resumed after last result");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("empty-frame beat not last");

    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("overflow flag before last beat");

endmodule

// ===== rtl/dcn_row_decode.sv =====
// Row assembly and box decode: collects one detection row, then scores,
// converts and clamps it in a two-stage pipeline. Depends on dcn_pkg.
module dcn_row_decode import dcn_pkg::*; #(
    parameter int MAX_CLASSES = MaxClassesDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beat,
    input  logic signed [31:0] i_value,
    input  logic               i_eor,
    input  logic               i_eof,
    input  t_cfg               i_cfg,
    output logic               o_cand_valid,
    output t_cand              o_cand
);

    function automatic t_span corner(input logic signed [31:0] c,
                                     input logic signed [31:0] s,
                                     input logic [12:0] lim);
        logic signed [34:0] a;
        logic signed [34:0] b;
        logic signed [34:0] top;
        logic signed [34:0] diff;
        t_span              r;
        top  = $signed({5'b0, lim, 17'b0});
        a    = $signed({{2{c[31]}}, c, 1'b0}) - $signed({{3{s[31]}}, s});
        b    = $signed({{2{c[31]}}, c, 1'b0}) + $signed({{3{s[31]}}, s});
        if (a < 0) a = '0;
        if (a > top) a = top;
        if (b < 0) b = '0;
        if (b > top) b = top;
        diff  = b - a;
        r.lo  = a[29:1];
        r.len = (b > a) ? diff[29:1] : '0;
        return r;
    endfunction

    logic [7:0]         r_pos, n_pos;
    logic signed [31:0] r_cx, n_cx, r_cy, n_cy, r_w, n_w, r_h, n_h, r_obj, n_obj;
    logic signed [31:0] r_best, n_best;
    logic [6:0]         r_bcls, n_bcls;
    logic               r_found, n_found;
    logic [7:0]         idx;

    logic               r_s1_v;
    logic signed [31:0] r_s1_cx, r_s1_cy, r_s1_w, r_s1_h, r_s1_obj, r_s1_best;
    logic [6:0]         r_s1_cls;
    logic               r_s1_found;

    logic               r_s2_v, r_s2_pass;
    logic [45:0]        r_s2_conf;
    t_span              r_s2_x, r_s2_y;
    logic [6:0]         r_s2_cls;

    logic [61:0]        prod;
    t_span              span_x, span_y;

    always_comb begin
        n_pos   = r_pos;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_w     = r_w;
        n_h     = r_h;
        n_obj   = r_obj;
        n_best  = r_best;
        n_bcls  = r_bcls;
        n_found = r_found;
        idx     = r_pos - 8'd5;
        unique case (r_pos)
            8'd0: n_cx  = i_value;
            8'd1: n_cy  = i_value;
            8'd2: n_w   = i_value;
            8'd3: n_h   = i_value;
            8'd4: n_obj = i_value;
            default: begin
                if (idx < {1'b0, i_cfg.num_classes} && idx < 8'(MAX_CLASSES)
                    && i_value > r_best) begin
                    n_best  = i_value;
                    n_bcls  = idx[6:0];
                    n_found = 1'b1;
                end
            end
        endcase
        if (r_pos != 8'hFF) n_pos = r_pos + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_w     <= '0;
            r_h     <= '0;
            r_obj   <= '0;
            r_best  <= '0;
            r_bcls  <= '0;
            r_found <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
        end else begin
            r_s1_v <= i_beat && (i_eor || i_eof);
            r_s2_v <= r_s1_v;
            if (i_beat) begin
                if (i_eor || i_eof) begin
                    r_pos   <= '0;
                    r_cx    <= '0;
                    r_cy    <= '0;
                    r_w     <= '0;
                    r_h     <= '0;
                    r_obj   <= '0;
                    r_best  <= '0;
                    r_bcls  <= '0;
                    r_found <= 1'b0;
                end else begin
                    r_pos   <= n_pos;
                    r_cx    <= n_cx;
                    r_cy    <= n_cy;
                    r_w     <= n_w;
                    r_h     <= n_h;
                    r_obj   <= n_obj;
                    r_best  <= n_best;
                    r_bcls  <= n_bcls;
                    r_found <= n_found;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_beat) begin
            r_s1_cx    <= n_cx;
            r_s1_cy    <= n_cy;
            r_s1_w     <= n_w;
            r_s1_h     <= n_h;
            r_s1_obj   <= n_obj;
            r_s1_best  <= n_best;
            r_s1_cls   <= n_bcls;
            r_s1_found <= n_found;
        end
    end

    assign prod   = r_s1_obj[30:0] * r_s1_best[30:0];
    assign span_x = corner(r_s1_cx, r_s1_w, i_cfg.net_width);
    assign span_y = corner(r_s1_cy, r_s1_h, i_cfg.net_height);

    always_ff @(posedge i_clk) begin
        r_s2_pass <= r_s1_found && (r_s1_obj > 0) && (r_s1_best > 0);
        r_s2_conf <= prod[61:16];
        r_s2_x    <= span_x;
        r_s2_y    <= span_y;
        r_s2_cls  <= r_s1_cls;
    end

    assign o_cand_valid = r_s2_v && r_s2_pass && (r_s2_conf > 46'(i_cfg.score_thr))
                          && (r_s2_x.len >= 29'd65536) && (r_s2_y.len >= 29'd65536);

    always_comb begin
        o_cand.left   = r_s2_x.lo;
        o_cand.width  = r_s2_x.len;
        o_cand.top    = r_s2_y.lo;
        o_cand.height = r_s2_y.len;
        o_cand.cls    = r_s2_cls;
        o_cand.score  = (r_s2_conf > 46'd65536) ? 17'd65536 : r_s2_conf[16:0];
    end

endmodule

// ===== rtl/dcn_iou.sv =====
// Division-free overlap test of two boxes, pipelined through overlap, area, union and threshold-product registers.
// Reports whether intersection over union exceeds the threshold. Depends on dcn_pkg.
module dcn_iou import dcn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_cand       i_a,
    input  t_cand       i_b,
    input  logic [16:0] i_thr,
    output logic        o_done,
    output logic        o_close
);

    logic [29:0] a_xe, b_xe, a_ye, b_ye, x_lo, x_hi, y_lo, y_hi;
    logic [29:0] ox, oy;
    logic        r_v1, r_v2, r_v3, r_v4;
    logic [28:0] r_ox, r_oy, r_aw, r_ah, r_bw, r_bh;
    logic [57:0] r_inter, r_a1, r_a2, r_inter3, r_inter4;
    logic [58:0] r_u;
    logic [48:0] r_plo;
    logic [43:0] r_phi;
    logic        r_uz;
    logic [76:0] rhs;
    logic [76:0] lhs;

    always_comb begin
        a_xe = {1'b0, i_a.left} + {1'b0, i_a.width};
        b_xe = {1'b0, i_b.left} + {1'b0, i_b.width};
        a_ye = {1'b0, i_a.top} + {1'b0, i_a.height};
        b_ye = {1'b0, i_b.top} + {1'b0, i_b.height};
        x_lo = (i_a.left > i_b.left) ? {1'b0, i_a.left} : {1'b0, i_b.left};
        x_hi = (a_xe < b_xe) ? a_xe : b_xe;
        y_lo = (i_a.top > i_b.top) ? {1'b0, i_a.top} : {1'b0, i_b.top};
        y_hi = (a_ye < b_ye) ? a_ye : b_ye;
        ox   = (x_hi > x_lo) ? x_hi - x_lo : '0;
        oy   = (y_hi > y_lo) ? y_hi - y_lo : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ox     <= ox[28:0];
        r_oy     <= oy[28:0];
        r_aw     <= i_a.width;
        r_ah     <= i_a.height;
        r_bw     <= i_b.width;
        r_bh     <= i_b.height;
        r_inter  <= r_ox * r_oy;
        r_a1     <= r_aw * r_ah;
        r_a2     <= r_bw * r_bh;
        r_u      <= {1'b0, r_a1} + {1'b0, r_a2} - {1'b0, r_inter};
        r_inter3 <= r_inter;
        r_plo    <= r_u[31:0] * i_thr;
        r_phi    <= r_u[58:32] * i_thr;
        r_uz     <= (r_u == '0);
        r_inter4 <= r_inter3;
    end

    assign rhs     = {1'b0, r_phi, 32'b0} + {28'b0, r_plo};
    assign lhs     = {3'b0, r_inter4, 16'b0};
    assign o_done  = r_v4;
    assign o_close = !r_uz && (lhs > rhs);

endmodule

// ===== rtl/dcn_nms.sv =====
// Candidate store, kept-box store and the suppression and emission sequencer.
// Depends on dcn_pkg and dcn_iou.
module dcn_nms import dcn_pkg::*; #(
    parameter int MAX_CANDIDATES = MaxCandidatesDef,
    parameter int MAX_KEPT       = MaxKeptDef,
    parameter int MAX_CLASSES    = MaxClassesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cand_valid,
    input  t_cand       i_cand,
    input  logic        i_eof_beat,
    input  logic [16:0] i_iou_thr,
    output logic        o_in_ready,
    output logic        o_out_valid,
    output t_result     o_out,
    input  logic        i_out_ready
);

    localparam int CAW = $clog2(MAX_CANDIDATES);
    localparam int CCW = $clog2(MAX_CANDIDATES + 1);
    localparam int KAW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int KCW = $clog2(MAX_KEPT + 1);

    t_cand cand_mem [MAX_CANDIDATES];
    logic  done_mem [MAX_CANDIDATES];
    t_cand kept_mem [MAX_KEPT];

    t_nms_state       r_state, n_state;
    logic             r_drain, n_drain;
    logic [7:0]       r_cls, n_cls;
    logic [CCW-1:0]   r_ccnt, n_ccnt, r_i, n_i;
    logic [KCW-1:0]   r_kcnt, n_kcnt, r_start, n_start, r_k, n_k;
    logic             r_ovf, n_ovf, r_have, n_have, r_rdv, n_rdv;
    logic [CAW-1:0]   r_rd_idx, n_rd_idx, r_pick_idx, n_pick_idx;
    t_cand            r_pick, n_pick;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic             cand_we, cand_rd, done_we, done_wdata, kept_re, kept_we, iou_start;
    logic [CAW-1:0]   done_waddr;
    t_cand            r_cand_q, r_kept_q;
    logic             r_done_q;
    logic             iou_done, iou_close;

    dcn_iou u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (iou_start),
        .i_a     (r_pick),
        .i_b     (r_kept_q),
        .i_thr   (i_iou_thr),
        .o_done  (iou_done),
        .o_close (iou_close)
    );

    always_comb begin
        n_state     = r_state;
        n_drain     = r_drain;
        n_cls       = r_cls;
        n_ccnt      = r_ccnt;
        n_i         = r_i;
        n_kcnt      = r_kcnt;
        n_start     = r_start;
        n_k         = r_k;
        n_ovf       = r_ovf;
        n_have      = r_have;
        n_rdv       = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_pick_idx  = r_pick_idx;
        n_pick      = r_pick;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        cand_rd     = 1'b0;
        kept_re     = 1'b0;
        kept_we     = 1'b0;
        iou_start   = 1'b0;
        cand_we     = i_cand_valid && (r_ccnt < CCW'(MAX_CANDIDATES));
        done_we     = cand_we;
        done_waddr  = r_ccnt[CAW-1:0];
        done_wdata  = 1'b0;
        if (cand_we) begin
            n_ccnt = r_ccnt + CCW'(1);
        end else if (i_cand_valid) begin
            n_ovf = 1'b1;
        end

        unique case (r_state)
            S_LOAD: begin
                if (i_eof_beat) begin
                    n_state = S_DRAIN;
                    n_drain = 1'b0;
                end
            end
            S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) n_state = S_CLASS;
            end
            S_CLASS: begin
                if (r_cls == 8'(MAX_CLASSES)) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_start = r_kcnt;
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                n_i     = '0;
                n_have  = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_i < r_ccnt) begin
                    cand_rd  = 1'b1;
                    n_rdv    = 1'b1;
                    n_rd_idx = r_i[CAW-1:0];
                    n_i      = r_i + CCW'(1);
                end
                if (r_rdv && !r_done_q && ({1'b0, r_cand_q.cls} == r_cls)
                    && (!r_have || r_cand_q.score > r_pick.score)) begin
                    n_pick     = r_cand_q;
                    n_pick_idx = r_rd_idx;
                    n_have     = 1'b1;
                end
                if (r_i >= r_ccnt && !r_rdv) begin
                    if (r_have) begin
                        n_state = S_MARK;
                    end else begin
                        n_cls   = r_cls + 8'd1;
                        n_state = S_CLASS;
                    end
                end
            end
            S_MARK: begin
                done_we    = 1'b1;
                done_waddr = r_pick_idx;
                done_wdata = 1'b1;
                n_k        = r_start;
                n_state    = S_CMP_RD;
            end
            S_CMP_RD: begin
                if (r_k == r_kcnt) begin
                    n_state = S_KEEP;
                end else begin
                    kept_re = 1'b1;
                    n_state = S_CMP_GO;
                end
            end
            S_CMP_GO: begin
                iou_start = 1'b1;
                n_state   = S_CMP_BUSY;
            end
            S_CMP_BUSY: begin
                if (iou_done) begin
                    if (iou_close) begin
                        n_state = S_PICK;
                    end else begin
                        n_k     = r_k + KCW'(1);
                        n_state = S_CMP_RD;
                    end
                end
            end
            S_KEEP: begin
                if (r_kcnt < KCW'(MAX_KEPT)) begin
                    kept_we = 1'b1;
                    n_kcnt  = r_kcnt + KCW'(1);
                end else begin
                    n_ovf = 1'b1;
                end
                n_state = S_PICK;
            end
            S_EMIT: begin
                if (r_kcnt == '0) begin
                    n_out       = '0;
                    n_out.none  = 1'b1;
                    n_out.ovf   = r_ovf;
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_OUT;
                end else begin
                    n_state = S_E_RD;
                end
            end
            S_E_RD: begin
                kept_re = 1'b1;
                n_state = S_E_LD;
            end
            S_E_LD: begin
                n_out.cand  = r_kept_q;
                n_out.none  = 1'b0;
                n_out.last  = (r_k + KCW'(1) == r_kcnt);
                n_out.ovf   = (r_k + KCW'(1) == r_kcnt) ? r_ovf : 1'b0;
                n_out_valid = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out.last) begin
                        n_ccnt  = '0;
                        n_kcnt  = '0;
                        n_ovf   = 1'b0;
                        n_cls   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + KCW'(1);
                        n_state = S_E_RD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_drain     <= 1'b0;
            r_cls       <= '0;
            r_ccnt      <= '0;
            r_i         <= '0;
            r_kcnt      <= '0;
            r_start     <= '0;
            r_k         <= '0;
            r_ovf       <= 1'b0;
            r_have      <= 1'b0;
            r_rdv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_drain     <= n_drain;
            r_cls       <= n_cls;
            r_ccnt      <= n_ccnt;
            r_i         <= n_i;
            r_kcnt      <= n_kcnt;
            r_start     <= n_start;
            r_k         <= n_k;
            r_ovf       <= n_ovf;
            r_have      <= n_have;
            r_rdv       <= n_rdv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_pick_idx <= n_pick_idx;
        r_pick     <= n_pick;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (cand_we) cand_mem[r_ccnt[CAW-1:0]] <= i_cand;
        if (cand_rd) r_cand_q <= cand_mem[r_i[CAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (done_we) done_mem[done_waddr] <= done_wdata;
        if (cand_rd) r_done_q <= done_mem[r_i[CAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (kept_we) kept_mem[r_kcnt[KAW-1:0]] <= r_pick;
        if (kept_re) r_kept_q <= kept_mem[r_k[KAW-1:0]];
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
